### rtl/core/pyramid_polygonal_match_search_macros.svh
`ifndef PYRAMID_POLYGONAL_MATCH_SEARCH_MACROS_SVH
`define PYRAMID_POLYGONAL_MATCH_SEARCH_MACROS_SVH

// Checks run on clock; they are held off while reset is high.
`define PPMS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// The condition in pre is followed in the next cycle by post.
`define PPMS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/ppms_pkg.sv
`timescale 1ns / 1ps

package ppms_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int SIDE_W          = 16;
   localparam int LIMIT_W         = 40;
   localparam int LAYER_W         = 32;
   localparam int INDEX_W         = 32;
   localparam int ROOT_STEPS      = 32;
   localparam int DIV_STEPS       = 33;
   localparam int CNT_W           = 6;
   localparam int CSR_AW          = 4;
   localparam int CSR_DW          = 64;

   localparam logic [SIDE_W-1:0]  SIDE_RESET  = 16'd3;
   localparam logic [SIDE_W-1:0]  MIN_SIDE    = 16'd3;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 40'd100000000000;
   localparam logic [LAYER_W-1:0] LAYER_START = 32'd2;

   // register index is paddr bit 3 (8-byte spacing)
   localparam logic REG_SIDE_COUNT  = 1'b0;
   localparam logic REG_VALUE_LIMIT = 1'b1;

   typedef enum logic [3:0] {
      OP_HOLD,
      OP_RESTART,
      OP_CHECK,
      OP_DISC_SQ,
      OP_DISC_LO,
      OP_DISC_HI,
      OP_ROOT,
      OP_DIV_SET,
      OP_DIV,
      OP_STEP_SQ,
      OP_STEP_LIN,
      OP_STEP_LO,
      OP_STEP_HI,
      OP_ADVANCE
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DISC_SQ,
      ST_DISC_LO,
      ST_DISC_HI,
      ST_ROOT,
      ST_DIV_SET,
      ST_DIV,
      ST_EMIT,
      ST_STEP_SQ,
      ST_STEP_LIN,
      ST_STEP_LO,
      ST_STEP_HI,
      ST_ADVANCE
   } state_type;

   typedef struct packed {
      op_type op;
      logic   emit;
   } ctl_type;

   typedef struct packed {
      logic over_limit;
      logic side_ok;
      logic perfect;
      logic finished;
   } sts_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  side_count;
      logic [LIMIT_W-1:0] value_limit;
   } cfg_type;

   typedef struct packed {
      logic [LAYER_W-1:0] layer_index;
      logic [LIMIT_W-1:0] pyramid_sum;
      logic               is_polygonal;
      logic [INDEX_W-1:0] polygon_index;
      logic               finished;
   } result_type;

endpackage

### rtl/core/ppms_ctrl.sv
`timescale 1ns / 1ps
`include "pyramid_polygonal_match_search_macros.svh"

module ppms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_restart,
   input  logic              slot_free,
   input  ppms_pkg::sts_type sts,
   output logic              req_ready,
   output ppms_pkg::ctl_type ctl
);

   localparam int CW = ppms_pkg::CNT_W;
   localparam logic [CW-1:0] ROOT_LAST = CW'(ppms_pkg::ROOT_STEPS - 1);
   localparam logic [CW-1:0] DIV_LAST  = CW'(ppms_pkg::DIV_STEPS - 1);

   ppms_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppms_pkg::ST_IDLE: begin
            if (req_valid && !req_restart) begin
               state_in = ppms_pkg::ST_CHECK;
            end
         end
         ppms_pkg::ST_CHECK: begin
            if (sts.over_limit || !sts.side_ok) begin
               state_in = ppms_pkg::ST_EMIT;
            end else begin
               state_in = ppms_pkg::ST_DISC_SQ;
            end
         end
         ppms_pkg::ST_DISC_SQ: state_in = ppms_pkg::ST_DISC_LO;
         ppms_pkg::ST_DISC_LO: state_in = ppms_pkg::ST_DISC_HI;
         ppms_pkg::ST_DISC_HI: state_in = ppms_pkg::ST_ROOT;
         ppms_pkg::ST_ROOT: begin
            if (cnt_ff == ROOT_LAST) begin
               state_in = ppms_pkg::ST_DIV_SET;
            end
         end
         ppms_pkg::ST_DIV_SET: begin
            if (sts.perfect) begin
               state_in = ppms_pkg::ST_DIV;
            end else begin
               state_in = ppms_pkg::ST_EMIT;
            end
         end
         ppms_pkg::ST_DIV: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = ppms_pkg::ST_EMIT;
            end
         end
         ppms_pkg::ST_EMIT: begin
            if (slot_free) begin
               state_in = sts.finished ? ppms_pkg::ST_IDLE : ppms_pkg::ST_STEP_SQ;
            end
         end
         ppms_pkg::ST_STEP_SQ:  state_in = ppms_pkg::ST_STEP_LIN;
         ppms_pkg::ST_STEP_LIN: state_in = ppms_pkg::ST_STEP_LO;
         ppms_pkg::ST_STEP_LO:  state_in = ppms_pkg::ST_STEP_HI;
         ppms_pkg::ST_STEP_HI:  state_in = ppms_pkg::ST_ADVANCE;
         ppms_pkg::ST_ADVANCE:  state_in = ppms_pkg::ST_IDLE;
         default:               state_in = ppms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (state_ff == ppms_pkg::ST_ROOT || state_ff == ppms_pkg::ST_DIV) begin
         cnt_in = cnt_ff + CW'(1);
      end else begin
         cnt_in = '0;
      end
   end

   always_comb begin
      req_ready = 1'b0;
      ctl.op    = ppms_pkg::OP_HOLD;
      ctl.emit  = 1'b0;
      unique case (state_ff)
         ppms_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_restart) begin
               ctl.op = ppms_pkg::OP_RESTART;
            end
         end
         ppms_pkg::ST_CHECK:    ctl.op = ppms_pkg::OP_CHECK;
         ppms_pkg::ST_DISC_SQ:  ctl.op = ppms_pkg::OP_DISC_SQ;
         ppms_pkg::ST_DISC_LO:  ctl.op = ppms_pkg::OP_DISC_LO;
         ppms_pkg::ST_DISC_HI:  ctl.op = ppms_pkg::OP_DISC_HI;
         ppms_pkg::ST_ROOT:     ctl.op = ppms_pkg::OP_ROOT;
         ppms_pkg::ST_DIV_SET:  ctl.op = ppms_pkg::OP_DIV_SET;
         ppms_pkg::ST_DIV:      ctl.op = ppms_pkg::OP_DIV;
         ppms_pkg::ST_EMIT:     ctl.emit = slot_free;
         ppms_pkg::ST_STEP_SQ:  ctl.op = ppms_pkg::OP_STEP_SQ;
         ppms_pkg::ST_STEP_LIN: ctl.op = ppms_pkg::OP_STEP_LIN;
         ppms_pkg::ST_STEP_LO:  ctl.op = ppms_pkg::OP_STEP_LO;
         ppms_pkg::ST_STEP_HI:  ctl.op = ppms_pkg::OP_STEP_HI;
         ppms_pkg::ST_ADVANCE:  ctl.op = ppms_pkg::OP_ADVANCE;
         default:               ctl.op = ppms_pkg::OP_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppms_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `PPMS_ASSERT_NEXT(a_root_len, state_ff == ppms_pkg::ST_ROOT && cnt_ff == ROOT_LAST, state_ff == ppms_pkg::ST_DIV_SET, "root sweep did not end after its last step")
   `PPMS_ASSERT_NEXT(a_over_emit, state_ff == ppms_pkg::ST_CHECK && sts.over_limit, state_ff == ppms_pkg::ST_EMIT && sts.finished, "sum over limit not reported as finished")
   `PPMS_ASSERT_NEXT(a_no_div, state_ff == ppms_pkg::ST_DIV_SET && !sts.perfect, state_ff == ppms_pkg::ST_EMIT, "division started on a non-square discriminant")
   `PPMS_ASSERT(a_div_cnt, state_ff == ppms_pkg::ST_DIV |-> cnt_ff <= DIV_LAST, "division ran past its last step")

endmodule

### rtl/core/ppms_dp.sv
`timescale 1ns / 1ps

module ppms_dp #(
   parameter int VALUE_WIDTH = ppms_pkg::VALUE_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ppms_pkg::cfg_type    cfg,
   input  ppms_pkg::ctl_type    ctl,
   output ppms_pkg::sts_type    sts,
   output ppms_pkg::result_type rslt
);

   localparam int SUM_W = (VALUE_WIDTH > 64) ? 64 : VALUE_WIDTH;
   localparam int DW    = 64;
   localparam int LW    = ppms_pkg::LAYER_W;

   localparam logic [DW-1:0] ROOT_BIT0 = 64'h4000_0000_0000_0000;
   localparam logic [5:0]    SH_NONE   = 6'd0;
   localparam logic [5:0]    SH_X8     = 6'd3;
   localparam logic [5:0]    SH_HI     = 6'd32;
   localparam logic [5:0]    SH_HI_X8  = 6'd35;

   logic [LW-1:0]    layer_ff, layer_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [DW-1:0]    acc_ff, acc_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    root_ff, root_in;
   logic [DW-1:0]    bit_ff, bit_in;
   logic             over_ff, over_in;
   logic             div_ran_ff, div_ran_in;

   logic [DW-1:0]    sum_w;
   logic [16:0]      s_m2, s_m4, den;
   logic [15:0]      d4;
   logic [LW-1:0]    layer_nx;
   logic [32:0]      num;
   logic [SUM_W-1:0] step_t, step_half;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [DW-1:0]      prod, shifted, mac_base, mac_out;
   logic [5:0]         mac_sh;
   logic               mac_sub, mac_acc;

   logic [DW-1:0] sub_a, sub_b;
   logic [DW:0]   sub_d;
   logic          borrow;
   logic [17:0]   trial;
   logic          match;

   assign sum_w    = DW'(sum_ff);
   assign s_m2     = {1'b0, cfg.side_count} - 17'd2;
   assign s_m4     = {1'b0, cfg.side_count} - 17'd4;
   assign den      = {cfg.side_count, 1'b0} - 17'd4;
   assign d4       = s_m4[16] ? (16'd4 - cfg.side_count) : s_m4[15:0];
   assign layer_nx = layer_ff + LW'(1);
   assign num      = {1'b0, root_ff[31:0]} + {17'b0, cfg.side_count} - 33'd4;
   assign step_t    = acc_ff[SUM_W-1:0];
   assign step_half = {step_t[SUM_W-1], step_t[SUM_W-1:1]};

   // shared multiply-accumulate
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mac_sh  = SH_NONE;
      mac_sub = 1'b0;
      mac_acc = 1'b0;
      unique case (ctl.op)
         ppms_pkg::OP_DISC_SQ: begin
            mul_a = {17'b0, d4};
            mul_b = {17'b0, d4};
         end
         ppms_pkg::OP_DISC_LO: begin
            mul_a   = {1'b0, sum_w[31:0]};
            mul_b   = {{16{s_m2[16]}}, s_m2};
            mac_sh  = SH_X8;
            mac_acc = 1'b1;
         end
         ppms_pkg::OP_DISC_HI: begin
            mul_a   = {1'b0, sum_w[63:32]};
            mul_b   = {{16{s_m2[16]}}, s_m2};
            mac_sh  = SH_HI_X8;
            mac_acc = 1'b1;
         end
         ppms_pkg::OP_STEP_SQ: begin
            mul_a = {1'b0, layer_nx};
            mul_b = {1'b0, layer_nx};
         end
         ppms_pkg::OP_STEP_LIN: begin
            mul_a   = {1'b0, layer_nx};
            mul_b   = {{16{s_m4[16]}}, s_m4};
            mac_sub = 1'b1;
         end
         ppms_pkg::OP_STEP_LO: begin
            mul_a   = {1'b0, rem_ff[31:0]};
            mul_b   = {{16{s_m2[16]}}, s_m2};
            mac_acc = 1'b1;
         end
         ppms_pkg::OP_STEP_HI: begin
            mul_a   = {1'b0, rem_ff[63:32]};
            mul_b   = {{16{s_m2[16]}}, s_m2};
            mac_sh  = SH_HI;
            mac_acc = 1'b1;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign prod     = mul_p[DW-1:0];
   assign shifted  = prod << mac_sh;
   assign mac_base = mac_acc ? acc_ff : '0;
   assign mac_out  = mac_sub ? (mac_base - shifted) : (mac_base + shifted);

   // shared subtract / compare
   assign trial = {rem_ff[16:0], root_ff[32]};

   always_comb begin
      sub_a = '0;
      sub_b = '0;
      unique case (ctl.op)
         ppms_pkg::OP_CHECK: begin
            sub_a = DW'(cfg.value_limit);
            sub_b = sum_w;
         end
         ppms_pkg::OP_ROOT: begin
            sub_a = rem_ff;
            sub_b = root_ff | bit_ff;
         end
         ppms_pkg::OP_DIV: begin
            sub_a = DW'(trial);
            sub_b = DW'(den);
         end
         default: begin
            sub_a = '0;
         end
      endcase
   end

   assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow = sub_d[DW];

   always_comb begin
      layer_in   = layer_ff;
      sum_in     = sum_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      bit_in     = bit_ff;
      over_in    = over_ff;
      div_ran_in = div_ran_ff;
      unique case (ctl.op)
         ppms_pkg::OP_RESTART: begin
            layer_in = ppms_pkg::LAYER_START;
            sum_in   = SUM_W'({1'b0, cfg.side_count} + 17'd1);
         end
         ppms_pkg::OP_CHECK: begin
            over_in    = borrow;
            div_ran_in = 1'b0;
         end
         ppms_pkg::OP_DISC_SQ, ppms_pkg::OP_DISC_LO: begin
            acc_in = mac_out;
         end
         ppms_pkg::OP_DISC_HI: begin
            rem_in  = mac_out;
            root_in = '0;
            bit_in  = ROOT_BIT0;
         end
         ppms_pkg::OP_ROOT: begin
            if (!borrow) begin
               rem_in  = sub_d[DW-1:0];
               root_in = (root_ff >> 1) | bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         ppms_pkg::OP_DIV_SET: begin
            if (rem_ff == '0) begin
               div_ran_in = 1'b1;
               root_in    = DW'(num);
            end
         end
         ppms_pkg::OP_DIV: begin
            rem_in  = DW'(borrow ? trial[16:0] : sub_d[16:0]);
            root_in = DW'({root_ff[31:0], !borrow});
         end
         ppms_pkg::OP_STEP_SQ: begin
            rem_in = mac_out;
         end
         ppms_pkg::OP_STEP_LIN, ppms_pkg::OP_STEP_LO, ppms_pkg::OP_STEP_HI: begin
            acc_in = mac_out;
         end
         ppms_pkg::OP_ADVANCE: begin
            layer_in = layer_nx;
            sum_in   = sum_ff + step_half;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff   <= ppms_pkg::LAYER_START;
         sum_ff     <= SUM_W'({1'b0, ppms_pkg::SIDE_RESET} + 17'd1);
         over_ff    <= 1'b0;
         div_ran_ff <= 1'b0;
      end else begin
         layer_ff   <= layer_in;
         sum_ff     <= sum_in;
         over_ff    <= over_in;
         div_ran_ff <= div_ran_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign match = div_ran_ff && (rem_ff == '0);

   assign sts.over_limit = borrow;
   assign sts.side_ok    = (cfg.side_count >= ppms_pkg::MIN_SIDE);
   assign sts.perfect    = (rem_ff == '0);
   assign sts.finished   = over_ff;

   assign rslt.layer_index   = layer_ff;
   assign rslt.pyramid_sum   = sum_ff[ppms_pkg::LIMIT_W-1:0];
   assign rslt.is_polygonal  = match;
   assign rslt.polygon_index = match ? root_ff[ppms_pkg::INDEX_W-1:0] : '0;
   assign rslt.finished      = over_ff;

endmodule

### rtl/core/pyramid_polygonal_match_search.sv
`timescale 1ns / 1ps
// Pyramidal / polygonal coincidence search for a programmable side count s.
// Request channel (req_*): one beat per command. restart=1 rewinds to layer
// two with sum 1+s and gives no response; restart=0 tests the current sum
// and then advances to the next layer.
// Response channel (rsp_*): one beat per test: layer, tested sum, match flag,
// polygon index, and finished once the sum is above value_limit.
// CSR port: side_count at 0x0, value_limit at 0x8; write only while idle.
// After the request beat, a finished sum or s below three goes straight to the
// response; a non-square discriminant stops after the square root; a match
// candidate also runs the division (3 multiply-accumulate steps, a 32-step
// square root and a 33-step division, all on one shared multiplier and one
// 64-bit subtractor). The layer advance then runs before req_ready returns,
// except once finished; a restart is taken without leaving idle.
// A response waits in an output register; if rsp_ready is low the block
// holds at that point and takes no new request until the slot frees.
// Reset: layer 2, sum 4, side_count 3, value_limit 100000000000, no response.

module pyramid_polygonal_match_search #(
   parameter int VALUE_WIDTH = ppms_pkg::VALUE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ppms_pkg::LAYER_W-1:0]   rsp_layer_index,
   output logic [ppms_pkg::LIMIT_W-1:0]   rsp_pyramid_sum,
   output logic                           rsp_is_polygonal,
   output logic [ppms_pkg::INDEX_W-1:0]   rsp_polygon_index,
   output logic                           rsp_finished,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ppms_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [ppms_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [ppms_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);

   localparam int DW = ppms_pkg::CSR_DW;

   ppms_pkg::cfg_type    cfg_ff, cfg_in;
   ppms_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ppms_pkg::ctl_type    ctl;
   ppms_pkg::sts_type    sts;
   ppms_pkg::result_type rslt;
   logic                 csr_wr;
   logic                 slot_free;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         if (csr_paddr[3] == ppms_pkg::REG_VALUE_LIMIT) begin
            cfg_in.value_limit = csr_pwdata[ppms_pkg::LIMIT_W-1:0];
         end else begin
            cfg_in.side_count = csr_pwdata[ppms_pkg::SIDE_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[3] == ppms_pkg::REG_VALUE_LIMIT) ?
                       DW'(cfg_ff.value_limit) : DW'(cfg_ff.side_count);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctl.emit) begin
         rsp_data_in  = rslt;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.side_count  <= ppms_pkg::SIDE_RESET;
         cfg_ff.value_limit <= ppms_pkg::LIMIT_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   ppms_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .slot_free   (slot_free),
      .sts         (sts),
      .req_ready   (req_ready),
      .ctl         (ctl)
   );

   ppms_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .ctl   (ctl),
      .sts   (sts),
      .rslt  (rslt)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_layer_index   = rsp_data_ff.layer_index;
   assign rsp_pyramid_sum   = rsp_data_ff.pyramid_sum;
   assign rsp_is_polygonal  = rsp_data_ff.is_polygonal;
   assign rsp_polygon_index = rsp_data_ff.polygon_index;
   assign rsp_finished      = rsp_data_ff.finished;

endmodule

### test/pyramid_polygonal_match_search_tb.sv
`timescale 1ns / 1ps

module pyramid_polygonal_match_search_tb;
   import ppms_pkg::*;

   localparam int RANDOM_ITEMS  = 850;
   localparam int SETTLE_CYCLES = 80;

   class match_scoreboard;
      logic [SIDE_W-1:0]  side;
      logic [LIMIT_W-1:0] limit;
      logic [LAYER_W-1:0] layer;
      logic [63:0]        sum;
      result_type         pending_reports[$];
      int unsigned        failures, tests, hits, finishes, restarts;

      function new();
         side      = SIDE_RESET;
         limit     = LIMIT_RESET;
         layer     = LAYER_START;
         sum       = 64'(SIDE_RESET) + 64'd1;
         failures  = 0;
         tests     = 0;
         hits      = 0;
         finishes  = 0;
         restarts  = 0;
      endfunction

      // floor sqrt, one result bit per operand bit pair
      function logic [63:0] floor_sqrt(logic [63:0] v);
         logic [63:0] rem, res, bitv;
         rem  = v;
         res  = '0;
         bitv = 64'h4000_0000_0000_0000;
         for (int k = 0; k < 32; k++) begin
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function void note_command(logic restart);
         result_type  want;
         logic [63:0] s, d4, disc, root, num, den, i, t, half;
         if (restart) begin
            restarts++;
            layer = LAYER_START;
            sum   = 64'(side) + 64'd1;
            return;
         end
         tests++;
         s = 64'(side);
         want = '0;
         want.layer_index = layer;
         want.pyramid_sum = sum[LIMIT_W-1:0];
         if (sum > 64'(limit)) begin
            // search holds until a restart
            want.finished = 1'b1;
            finishes++;
            pending_reports.push_back(want);
            return;
         end
         if (s >= 64'(MIN_SIDE)) begin
            d4   = (s >= 64'd4) ? s - 64'd4 : 64'd4 - s;
            disc = d4 * d4 + 64'd8 * (s - 64'd2) * sum;
            root = floor_sqrt(disc);
            if (root * root == disc) begin
               num = s + root - 64'd4;
               den = 64'd2 * s - 64'd4;
               if (num % den == 64'd0) begin
                  want.is_polygonal  = 1'b1;
                  want.polygon_index = INDEX_W'(num / den);
                  hits++;
               end
            end
         end
         pending_reports.push_back(want);
         layer = layer + 32'd1;
         i     = 64'(layer);
         t     = i * i * (s - 64'd2) - i * (s - 64'd4);
         half  = (t >> 1) | (t & 64'h8000_0000_0000_0000);
         sum   = sum + half;
      endfunction

      function void field_check(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s expected %0d got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_report(result_type got);
         result_type want;
         if (pending_reports.size() == 0) begin
            $error("response beat with nothing outstanding, layer %0d", got.layer_index);
            failures++;
            return;
         end
         want = pending_reports.pop_front();
         field_check("layer_index", want.layer_index, got.layer_index);
         field_check("pyramid_sum", want.pyramid_sum, got.pyramid_sum);
         field_check("is_polygonal", want.is_polygonal, got.is_polygonal);
         field_check("polygon_index", want.polygon_index, got.polygon_index);
         field_check("finished", want.finished, got.finished);
      endfunction

      function void close_out();
         if (pending_reports.size() != 0) begin
            $error("%0d responses never arrived", pending_reports.size());
            failures += pending_reports.size();
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_restart;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [LAYER_W-1:0]  rsp_layer_index;
   logic [LIMIT_W-1:0]  rsp_pyramid_sum;
   logic                rsp_is_polygonal;
   logic [INDEX_W-1:0]  rsp_polygon_index;
   logic                rsp_finished;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   match_scoreboard     sb;
   result_type          seen;
   int                  idle_pct = 31;
   int                  settings = 0;

   pyramid_polygonal_match_search u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_layer_index   (rsp_layer_index),
      .rsp_pyramid_sum   (rsp_pyramid_sum),
      .rsp_is_polygonal  (rsp_is_polygonal),
      .rsp_polygon_index (rsp_polygon_index),
      .rsp_finished      (rsp_finished),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.layer_index   = rsp_layer_index;
         seen.pyramid_sum   = rsp_pyramid_sum;
         seen.is_polygonal  = rsp_is_polygonal;
         seen.polygon_index = rsp_polygon_index;
         seen.finished      = rsp_finished;
         sb.check_report(seen);
      end
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   task automatic send_command(input logic restart);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      sb.note_command(restart);
   endtask

   task automatic csr_access(input logic wr, input logic idx, input logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_search(input logic [SIDE_W-1:0] s, input logic [LIMIT_W-1:0] lim);
      logic [CSR_DW-1:0] rd;
      csr_access(1'b1, REG_SIDE_COUNT, CSR_DW'(s), rd);
      csr_access(1'b1, REG_VALUE_LIMIT, CSR_DW'(lim), rd);
      sb.side  = s;
      sb.limit = lim;
      csr_access(1'b0, REG_SIDE_COUNT, '0, rd);
      if (rd[SIDE_W-1:0] !== s) begin
         $error("side_count readback expected %0d got %0d", s, rd[SIDE_W-1:0]);
         sb.failures++;
      end
      csr_access(1'b0, REG_VALUE_LIMIT, '0, rd);
      if (rd[LIMIT_W-1:0] !== lim) begin
         $error("value_limit readback expected %0d got %0d", lim, rd[LIMIT_W-1:0]);
         sb.failures++;
      end
      settings++;
   endtask

   // drain responses, then let a trailing restart settle
   task automatic quiesce();
      req_valid <= 1'b0;
      while (sb.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_setting(output logic [SIDE_W-1:0] s, output logic [LIMIT_W-1:0] lim);
      case ($urandom_range(0, 5))
         0, 1: s = MIN_SIDE;
         2: s = SIDE_W'($urandom_range(4, 12));
         3: s = SIDE_W'($urandom_range(0, 2));
         4: s = '1;
         default: s = SIDE_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: lim = '0;
         1: lim = '1;
         2: lim = LIMIT_RESET;
         3: lim = LIMIT_W'($urandom_range(0, 20000));
         default: lim = {8'($urandom), 32'($urandom)};
      endcase
   endtask

   initial begin
      #10_000_000;
      $display("pyramid_polygonal_match_search verification failed");
      $finish;
   end

   initial begin
      int                 sent;
      int                 run;
      logic [SIDE_W-1:0]  s;
      logic [LIMIT_W-1:0] lim;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_restart = 1'b0;
      rsp_ready   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state, then matches at 10 and 120
      repeat (2) send_command(1'b0);
      quiesce();
      set_search(MIN_SIDE, '1);
      send_command(1'b1);
      repeat (7) send_command(1'b0);
      quiesce();
      set_search(MIN_SIDE, '0);
      repeat (2) send_command(1'b0);
      quiesce();
      set_search('1, '1);
      send_command(1'b1);
      repeat (3) send_command(1'b0);
      quiesce();
      // side below three: negative step wraps the sum
      set_search('0, '1);
      send_command(1'b1);
      repeat (4) send_command(1'b0);

      sent = 0;
      for (int phase = 0; phase < 10; phase++) begin
         quiesce();
         pick_setting(s, lim);
         set_search(s, lim);
         idle_pct = (phase == 5) ? 0 : 31;
         while (sent < RANDOM_ITEMS * (phase + 1) / 10) begin
            if ($urandom_range(9) != 0) begin
               send_command(1'b1);
               sent++;
            end
            run = $urandom_range(1, 40);
            repeat (run) begin
               send_command(1'b0);
               sent++;
            end
         end
      end
      quiesce();
      sb.close_out();
      $display("covered %0d tests (%0d polygonal, %0d past the limit) and %0d restarts",
               sb.tests, sb.hits, sb.finishes, sb.restarts);
      $display("across %0d register settings", settings);
      if (sb.failures == 0) begin
         $display("pyramid_polygonal_match_search verification clean");
      end else begin
         $display("pyramid_polygonal_match_search verification failed");
      end
      $finish;
   end

endmodule
